FILE: hdl/obb_pkg.sv
// Package for the oriented box collision checker: types, codes and polynomial constants.
// No dependencies.
package obb_pkg;

  localparam int unsigned DefMaxObstacles = 64;
  localparam int unsigned DefAngleBits    = 16;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAdd    = 2'd1;
  localparam logic [1:0] CmdCheck  = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [2:0] RegHalfLen = 3'd0;
  localparam logic [2:0] RegHalfWid = 3'd1;
  localparam logic [2:0] RegXMin    = 3'd2;
  localparam logic [2:0] RegXMax    = 3'd3;
  localparam logic [2:0] RegYMin    = 3'd4;
  localparam logic [2:0] RegYMax    = 3'd5;

  localparam logic [17:0] QwA = 18'd25736;
  localparam logic [17:0] QwB = 18'd10512;
  localparam logic [17:0] QwC = 18'd1160;
  localparam logic [16:0] OneQ15 = 17'd32768;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        hx;
    logic [30:0]        hy;
  } obstacle_t;

endpackage

FILE: hdl/obb_mem.sv
// Obstacle table: one synchronous memory, one write and one registered read port.
// Depends on obb_pkg.
module obb_mem import obb_pkg::*; #(
  parameter int unsigned Depth = DefMaxObstacles,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  obstacle_t        wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output obstacle_t        rdata_o
);
  obstacle_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hdl/obb_sat.sv
// Datapath: sine pipeline (four stages, one multiply each) and the separating axis test
// pipeline (one obstacle per cycle, three stages). Depends on obb_pkg.
module obb_sine import obb_pkg::*; (
  input  logic               clk_i,
  input  logic [15:0]        phase_i,
  output logic signed [17:0] sin_o
);
  // quarter-wave polynomial, x in Q14, result Q1.15 clamped, sign from the top phase bit
  logic [14:0] x_a;
  logic [29:0] xx_a;
  logic [14:0] xa_q, xb_q, xc_q;
  logic [15:0] za_q, zb_q;
  logic [17:0] tb_q, tc_q;
  logic [2:0]  neg_q;
  logic [33:0] p1, p2, p3;
  logic [17:0] u;
  logic [16:0] mag;

  assign x_a  = phase_i[14] ? 15'(15'd16384 - {1'b0, phase_i[13:0]}) : {1'b0, phase_i[13:0]};
  assign xx_a = 30'(x_a) * 30'(x_a);
  assign p1   = 34'(QwC) * 34'(za_q);
  assign p2   = 34'(tb_q) * 34'(zb_q);
  assign p3   = 34'(tc_q) * 34'(xc_q);
  assign u    = 18'(p3 >> 13);
  assign mag  = (u > 18'(OneQ15)) ? OneQ15 : u[16:0];

  always_ff @(posedge clk_i) begin
    xa_q  <= x_a;
    za_q  <= xx_a[29:14];
    xb_q  <= xa_q;
    zb_q  <= za_q;
    tb_q  <= QwB - 18'(p1 >> 14);
    xc_q  <= xb_q;
    tc_q  <= QwA - 18'(p2 >> 14);
    neg_q <= {neg_q[1:0], phase_i[15]};
    sin_o <= neg_q[2] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end
endmodule

module obb_sat import obb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  input  obstacle_t          obs_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [17:0] cos_i,
  input  logic signed [17:0] sin_i,
  input  logic [30:0]        len_i,
  input  logic [30:0]        wid_i,
  output logic               hit_vld_o,
  output logic               hit_o
);
  logic [17:0] ac, as;
  assign ac = cos_i[17] ? 18'(-cos_i) : 18'(cos_i);
  assign as = sin_i[17] ? 18'(-sin_i) : 18'(sin_i);

  // stage 1: differences
  logic v1_q;
  logic signed [32:0] dx_q, dy_q;
  logic [30:0] hx1_q, hy1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= in_vld_i;
  end
  always_ff @(posedge clk_i) begin
    dx_q  <= 33'(px_i) - 33'(obs_i.cx);
    dy_q  <= 33'(py_i) - 33'(obs_i.cy);
    hx1_q <= obs_i.hx;
    hy1_q <= obs_i.hy;
  end

  // stage 2: products
  logic v2_q;
  logic signed [51:0] dxc_q, dys_q, dyc_q, dxs_q;
  logic [48:0] hxac_q, hxas_q, hyac_q, hyas_q;
  logic [33:0] adx_q, ady_q;
  logic [30:0] hx2_q, hy2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    dxc_q  <= 52'(dx_q) * 52'(cos_i);
    dys_q  <= 52'(dy_q) * 52'(sin_i);
    dyc_q  <= 52'(dy_q) * 52'(cos_i);
    dxs_q  <= 52'(dx_q) * 52'(sin_i);
    hxac_q <= 49'(hx1_q) * 49'(ac);
    hxas_q <= 49'(hx1_q) * 49'(as);
    hyac_q <= 49'(hy1_q) * 49'(ac);
    hyas_q <= 49'(hy1_q) * 49'(as);
    adx_q  <= dx_q[32] ? 34'(-dx_q) : 34'(dx_q);
    ady_q  <= dy_q[32] ? 34'(-dy_q) : 34'(dy_q);
    hx2_q  <= hx1_q;
    hy2_q  <= hy1_q;
  end

  // car-side products only change with config/pose
  logic [48:0] lac, las, wac, was;
  assign lac = 49'(len_i) * 49'(ac);
  assign las = 49'(len_i) * 49'(as);
  assign wac = 49'(wid_i) * 49'(ac);
  assign was = 49'(wid_i) * 49'(as);

  // stage 3: sums and compares
  logic v3_q, sep_q;
  logic signed [53:0] pa, pb;
  logic [53:0] apa, apb;
  logic [53:0] l0, r0, l1, r1, r2, r3;
  always_comb begin
    pa  = 54'(dxc_q) + 54'(dys_q);
    pb  = 54'(dyc_q) - 54'(dxs_q);
    apa = pa[53] ? 54'(-pa) : 54'(pa);
    apb = pb[53] ? 54'(-pb) : 54'(pb);
    l0  = {5'd0, adx_q, 15'd0};
    l1  = {5'd0, ady_q, 15'd0};
    r0  = {8'd0, hx2_q, 15'd0} + 54'(lac) + 54'(was);
    r1  = {8'd0, hy2_q, 15'd0} + 54'(las) + 54'(wac);
    r2  = {8'd0, len_i, 15'd0} + 54'(hxac_q) + 54'(hyas_q);
    r3  = {8'd0, wid_i, 15'd0} + 54'(hxas_q) + 54'(hyac_q);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    sep_q <= (l0 >= r0) || (l1 >= r1) || (apa >= r2) || (apb >= r3);
  end

  assign hit_vld_o = v3_q;
  assign hit_o     = !sep_q;
endmodule

FILE: hdl/oriented_box_collision_check.sv
// Oriented car box against a table of axis-aligned obstacles (top level).
// Clear, add, unused, out-of-bounds or empty-table check answers without a walk; an in-bounds
// check of N obstacles held runs the sine pipeline, one memory read per cycle, 3-stage axis test.
// One request at a time; the next is taken the cycle after the result has left, so an output stall
// holds it off. Reset clears the count and control registers and loads configuration defaults;
// the table contents stay undefined.
module oriented_box_collision_check import obb_pkg::*; #(
  parameter int unsigned MaxObstacles = DefMaxObstacles,
  parameter int unsigned AngleBits    = DefAngleBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [15:0]        heading_i,
  input  logic [30:0]        half_size_x_i,
  input  logic [30:0]        half_size_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               pose_valid_o,
  output logic               status_o,
  output logic [6:0]         stored_count_o
);
  // Depends on obb_pkg, obb_mem, obb_sine and obb_sat.
  localparam int unsigned AddrW = (MaxObstacles > 1) ? $clog2(MaxObstacles) : 1;
  localparam int unsigned CntW  = $clog2(MaxObstacles + 1);
  // heading to a 16-bit phase: low AngleBits bits span the full circle
  localparam int unsigned PhUp   = (AngleBits < 16) ? 16 - AngleBits : 0;
  localparam int unsigned PhDown = (AngleBits > 16) ? AngleBits - 16 : 0;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StWalk = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  // configuration registers
  logic [30:0] len_q, wid_q;
  logic signed [31:0] xmin_q, xmax_q, ymin_q, ymax_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= 31'd65536;
      wid_q  <= 31'd32768;
      xmin_q <= 32'sh8000_0000;
      xmax_q <= 32'sh7fff_ffff;
      ymin_q <= 32'sh8000_0000;
      ymax_q <= 32'sh7fff_ffff;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHalfLen: len_q  <= cfg_data_i[30:0];
        RegHalfWid: wid_q  <= cfg_data_i[30:0];
        RegXMin:    xmin_q <= cfg_data_i;
        RegXMax:    xmax_q <= cfg_data_i;
        RegYMin:    ymin_q <= cfg_data_i;
        RegYMax:    ymax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  logic [1:0] st_q;
  logic prep_q;
  logic [CntW-1:0] cnt_q, rd_q, seen_q;
  logic hit_q;
  logic out_v_q, pv_q, stat_q;
  logic signed [31:0] px_q, py_q;
  logic [15:0] phase_q;
  logic signed [17:0] cos_v, sin_v;

  logic acc;
  assign in_stall_o = (st_q != StIdle) || out_v_q;
  assign acc = in_valid_i && !in_stall_o;

  logic [15:0] phase, phase_cos;
  assign phase     = 16'((32'(heading_i) << PhUp) >> PhDown);
  assign phase_cos = phase_q + 16'd16384;

  logic in_bnd;
  assign in_bnd = (pos_x_i >= xmin_q) && (pos_x_i <= xmax_q) &&
                  (pos_y_i >= ymin_q) && (pos_y_i <= ymax_q);

  // memory
  obstacle_t wdat, rdat;
  logic we;
  assign we = acc && (cmd_i == CmdAdd) && (cnt_q < CntW'(MaxObstacles));
  assign wdat = '{cx: pos_x_i, cy: pos_y_i, hx: half_size_x_i, hy: half_size_y_i};

  obb_mem #(.Depth(MaxObstacles), .AddrW(AddrW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(cnt_q[AddrW-1:0]), .wdata_i(wdat),
    .raddr_i(rd_q[AddrW-1:0]), .rdata_o(rdat)
  );

  // sine and cosine come from the obb_sine pipelines fed by the registered heading phase
  obb_sine u_sin (.clk_i, .phase_i(phase_q), .sin_o(sin_v));
  obb_sine u_cos (.clk_i, .phase_i(phase_cos), .sin_o(cos_v));

  logic rd_vld_q;
  logic hv, hit;
  obb_sat u_sat (
    .clk_i, .rst_ni, .in_vld_i(rd_vld_q), .obs_i(rdat),
    .px_i(px_q), .py_i(py_q), .cos_i(cos_v), .sin_i(sin_v),
    .len_i(len_q), .wid_i(wid_q), .hit_vld_o(hv), .hit_o(hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; prep_q <= 1'b0; cnt_q <= '0; rd_q <= '0; seen_q <= '0; hit_q <= 1'b0;
      out_v_q <= 1'b0; pv_q <= 1'b0; stat_q <= 1'b0; rd_vld_q <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      rd_vld_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (acc) begin
            pv_q <= 1'b0; stat_q <= 1'b0;
            case (cmd_i)
              CmdClear: begin cnt_q <= '0; out_v_q <= 1'b1; end
              CmdAdd: begin
                if (we) cnt_q <= cnt_q + 1'b1;
                else stat_q <= 1'b1;
                out_v_q <= 1'b1;
              end
              CmdCheck: begin
                if (in_bnd && cnt_q != '0) begin
                  st_q <= StPrep; prep_q <= 1'b1;
                  rd_q <= '0; seen_q <= '0; hit_q <= 1'b0;
                end else begin
                  pv_q <= in_bnd; out_v_q <= 1'b1;
                end
              end
              default: out_v_q <= 1'b1;
            endcase
          end
        end
        StPrep: begin
          // prep_q stretches this state so the sine is settled by the first product stage
          if (prep_q) prep_q <= 1'b0;
          else st_q <= StWalk;
        end
        StWalk: begin
          // issue reads; rd_vld_q marks data arriving next cycle
          if (rd_q < cnt_q) begin
            rd_vld_q <= 1'b1;
            rd_q <= rd_q + 1'b1;
          end
          if (hv) begin
            seen_q <= seen_q + 1'b1;
            if (hit) hit_q <= 1'b1;
            if (seen_q + 1'b1 == cnt_q) st_q <= StDone;
          end
        end
        StDone: begin
          pv_q <= !hit_q; out_v_q <= 1'b1; st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      phase_q <= phase;
    end
  end

  assign out_valid_o    = out_v_q;
  assign pose_valid_o   = pv_q;
  assign status_o       = stat_q;
  assign stored_count_o = 7'(cnt_q);

  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !acc) else $error("request taken while busy");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxObstacles)) else $error("count overflow");
  a_full_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd_i == CmdAdd && cnt_q == CntW'(MaxObstacles)) |=> stat_q)
    else $error("full table not flagged");
endmodule
